// ===== design/normal_matrix_3x3_top_macros.svh =====
// Assertion macros for the normal matrix block.
`ifndef NORMAL_MATRIX_3X3_TOP_MACROS_SVH
`define NORMAL_MATRIX_3X3_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normal matrix: implication check failed");
`define NM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normal matrix: next-cycle check failed");
`else
`define NM_ASSERT_IMP(lbl, ante, cons)
`define NM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/nm_pkg.sv =====
// Shared types, constants and binary32 arithmetic helpers for the normal matrix block.
package nm_pkg;

  localparam int NUM_ELEM      = 9;
  localparam int FP_W          = 32;
  localparam int MAT_W         = NUM_ELEM * FP_W;
  localparam int RAW_W         = 50;
  localparam int DIV_STEPS     = 28;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
  localparam int MUL_LAT       = 2;
  localparam int ADD_LAT       = 2;
  localparam int C0_DELAY      = MUL_LAT + ADD_LAT;
  localparam int K_DELAY       = 22;
  localparam int PIPE_LAT      = 29;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_TINY = 32'h1E3C_E508;

  typedef logic [FP_W-1:0] fp_t;

  // unrounded value: m * 2^e, or a finished special value
  typedef struct packed {
    logic              spec;
    fp_t               sv;
    logic              sign;
    logic [RAW_W-1:0]  m;
    logic signed [10:0] e;
  } fp_raw_t;

  typedef struct packed {
    logic        deg;
    logic        sign;
    logic [7:0]  ed;
    logic [23:0] md;
    logic [23:0] rem;
    logic [27:0] q;
  } div_st_t;

  function automatic logic fp_is_nan(input fp_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input fp_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(input fp_t a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] fp_mant(input fp_t a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic logic [7:0] fp_exp(input fp_t a);
    return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  endfunction

  function automatic fp_t fp_canon(input fp_t a);
    return fp_is_nan(a) ? FP_QNAN : a;
  endfunction

  // normalise, round to nearest even, pack (gradual underflow, overflow to inf)
  function automatic fp_t fp_round(input fp_raw_t r);
    logic [5:0]         lz;
    logic [RAW_W-1:0]   mn;
    logic [RAW_W-1:0]   ms;
    logic signed [12:0] be;
    logic [6:0]         sh;
    logic               st;
    logic               inc;
    logic [23:0]        kept;
    logic [7:0]         ef;
    logic [30:0]        w;
    fp_t                res;
    lz = 6'd0;
    for (int i = 0; i < RAW_W; i++) begin
      if (r.m[i]) lz = 6'(RAW_W - 1 - i);
    end
    mn = r.m << lz;
    be = 13'(r.e) - $signed({7'd0, lz}) + 13'sd176;
    if (be < 13'sd1) begin
      sh = (be < -13'sd62) ? 7'd63 : 7'(13'sd1 - be);
      ms = mn >> sh;
      st = (ms << sh) != mn;
      ef = 8'd0;
    end else begin
      sh = 7'd0;
      ms = mn;
      st = 1'b0;
      ef = be[7:0];
    end
    kept = ms[RAW_W-1:RAW_W-24];
    inc  = ms[RAW_W-25] & ((|ms[RAW_W-26:0]) | st | kept[0]);
    w    = {ef, kept[22:0]} + 31'(inc);
    if (r.spec) res = r.sv;
    else if (r.m == '0) res = {r.sign, 31'd0};
    else if (be >= 13'sd255) res = {r.sign, 8'hFF, 23'd0};
    else res = {r.sign, w};
    return res;
  endfunction

  function automatic fp_raw_t fp_mul_front(input fp_t a, input fp_t b);
    fp_raw_t     r;
    logic [47:0] p;
    r      = '0;
    r.sign = a[31] ^ b[31];
    p      = fp_mant(a) * fp_mant(b);
    r.m    = {2'b00, p};
    r.e    = $signed({3'b000, fp_exp(a)}) + $signed({3'b000, fp_exp(b)}) - 11'sd300;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b)) ||
        (fp_is_zero(a) && fp_is_inf(b))) begin
      r.spec = 1'b1;
      r.sv   = FP_QNAN;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      r.spec = 1'b1;
      r.sv   = {r.sign, 8'hFF, 23'd0};
    end else if (fp_is_zero(a) || fp_is_zero(b)) begin
      r.spec = 1'b1;
      r.sv   = {r.sign, 31'd0};
    end
    return r;
  endfunction

  function automatic fp_raw_t fp_add_front(input fp_t a, input fp_t b);
    fp_raw_t     r;
    fp_t         hi;
    fp_t         lo;
    logic [7:0]  diff;
    logic [26:0] ml;
    logic [26:0] msl;
    logic [26:0] shd;
    logic        stk;
    logic [27:0] sum;
    r  = '0;
    hi = (a[30:0] >= b[30:0]) ? a : b;
    lo = (a[30:0] >= b[30:0]) ? b : a;
    diff = fp_exp(hi) - fp_exp(lo);
    ml   = {fp_mant(hi), 3'b000};
    msl  = {fp_mant(lo), 3'b000};
    if (diff >= 8'd27) begin
      shd = 27'd0;
      stk = |msl;
    end else begin
      shd = msl >> diff;
      stk = (shd << diff) != msl;
    end
    shd[0] = shd[0] | stk;
    if (a[31] ^ b[31]) sum = {1'b0, ml} - {1'b0, shd};
    else sum = {1'b0, ml} + {1'b0, shd};
    r.m = {22'd0, sum};
    r.e = $signed({3'b000, fp_exp(hi)}) - 11'sd153;
    if (sum == 28'd0) r.sign = (a[31] ^ b[31]) ? 1'b0 : a[31];
    else r.sign = hi[31];
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))) begin
      r.spec = 1'b1;
      r.sv   = FP_QNAN;
    end else if (fp_is_inf(a)) begin
      r.spec = 1'b1;
      r.sv   = a;
    end else if (fp_is_inf(b)) begin
      r.spec = 1'b1;
      r.sv   = b;
    end
    return r;
  endfunction

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     o;
    logic [24:0] t;
    o = s;
    t = {s.rem, 1'b0};
    if (t >= {1'b0, s.md}) begin
      o.rem = 24'(t - {1'b0, s.md});
      o.q   = {s.q[26:0], 1'b1};
    end else begin
      o.rem = t[23:0];
      o.q   = {s.q[26:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic mat_is_identity(input logic [MAT_W-1:0] x);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < NUM_ELEM; j++) begin
      if (x[j*FP_W +: FP_W] != (((j % 4) == 0) ? FP_ONE : FP_ZERO)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic mat_nan_canon(input logic [MAT_W-1:0] x);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < NUM_ELEM; j++) begin
      if (fp_is_nan(x[j*FP_W +: FP_W]) && (x[j*FP_W +: FP_W] != FP_QNAN)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== design/nm_delay.sv =====
// Enable-gated shift register delay line.
module nm_delay import nm_pkg::*; #(
  parameter int W     = FP_W,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

// ===== design/nm_fp_mul.sv =====
// Two-stage binary32 multiplier: mantissa product, then normalise and round.
module nm_fp_mul import nm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fp_t  a,
  input  fp_t  b,
  output fp_t  y
);

  fp_raw_t raw_r;
  fp_raw_t raw_nxt;
  fp_t     y_r;
  fp_t     y_nxt;

  assign raw_nxt = fp_mul_front(a, b);
  assign y_nxt   = fp_round(raw_r);

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= raw_nxt;
      y_r   <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== design/nm_fp_add.sv =====
// Two-stage binary32 adder: align and add, then normalise and round.
module nm_fp_add import nm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fp_t  a,
  input  fp_t  b,
  output fp_t  y
);

  fp_raw_t raw_r;
  fp_raw_t raw_nxt;
  fp_t     y_r;
  fp_t     y_nxt;

  assign raw_nxt = fp_add_front(a, b);
  assign y_nxt   = fp_round(raw_r);

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= raw_nxt;
      y_r   <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== design/nm_recip.sv =====
// Pipelined reciprocal of the determinant with degenerate check; radix-2, two bits a stage.
module nm_recip import nm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fp_t  d,
  output fp_t  r,
  output logic deg
);

  div_st_t st_r [DIV_STAGES+1];
  div_st_t st_nxt [DIV_STAGES+1];
  fp_raw_t raw;
  fp_t     r_r;
  logic    deg_r;

  // unpack; remainder starts at 2^22 so the quotient is 2^50 / mantissa
  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].deg  = (d[30:23] == 8'hFF) || (d[30:0] <= FP_TINY[30:0]);
    st_nxt[0].sign = d[31];
    st_nxt[0].ed   = d[30:23];
    st_nxt[0].md   = {1'b1, d[22:0]};
    st_nxt[0].rem  = 24'h40_0000;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      st_nxt[g+1] = st_r[g];
      for (int s = 0; s < DIV_PER_STAGE; s++) st_nxt[g+1] = div_step(st_nxt[g+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= DIV_STAGES; i++) st_r[i] <= st_nxt[i];
    end
  end

  always_comb begin
    raw      = '0;
    raw.sign = st_r[DIV_STAGES].sign;
    raw.m    = {21'd0, st_r[DIV_STAGES].q, st_r[DIV_STAGES].rem != 24'd0};
    raw.e    = 11'sd99 - $signed({3'b000, st_r[DIV_STAGES].ed});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= fp_round(raw);
      deg_r <= st_r[DIV_STAGES].deg;
    end
  end

  assign r   = r_r;
  assign deg = deg_r;

endmodule

// ===== design/normal_matrix_3x3_top.sv =====
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output register.
// Longest section is the reciprocal: 14 stages of two radix-2 divide steps.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
module normal_matrix_3x3_top import nm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z
  input  logic [MAT_W-1:0] in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // res0_x, res0_y, res0_z, res1_x, res1_y, res1_z, res2_x, res2_y, res2_z
  output logic [MAT_W-1:0] out_tdata,
  // degenerate
  output logic             out_tuser
);

`include "normal_matrix_3x3_top_macros.svh"

  // global advance: output register free or being drained
  logic                en;
  logic [PIPE_LAT-1:0] v_r;
  logic [PIPE_LAT-1:0] v_nxt;

  fp_t c   [NUM_ELEM];
  fp_t k   [NUM_ELEM];
  fp_t kd  [NUM_ELEM];
  fp_t y   [NUM_ELEM];
  fp_t c0d [3];
  fp_t pd  [3];
  fp_t pzd;
  fp_t s;
  fp_t det;
  fp_t rcp;
  logic deg;
  logic degd;

  logic [MAT_W-1:0] out_data_r;
  logic [MAT_W-1:0] out_data_nxt;
  logic             out_deg_r;
  logic             out_deg_nxt;

  assign en        = !v_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;
  assign v_nxt     = {v_r[PIPE_LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  for (genvar j = 0; j < NUM_ELEM; j++) begin : g_unpack
    assign c[j] = in_tdata[j*FP_W +: FP_W];
  end

  // cofactors: column i = c[i+1] x c[i+2], element e = l[e+1]*r[e+2] - l[e+2]*r[e+1]
  for (genvar j = 0; j < NUM_ELEM; j++) begin : g_cof
    localparam int LI = ((j / 3) + 1) % 3;
    localparam int RI = ((j / 3) + 2) % 3;
    localparam int E1 = ((j % 3) + 1) % 3;
    localparam int E2 = ((j % 3) + 2) % 3;
    fp_t p;
    fp_t q;
    nm_fp_mul u_mp (.clk(clk), .en(en), .a(c[3*LI+E1]), .b(c[3*RI+E2]), .y(p));
    nm_fp_mul u_mq (.clk(clk), .en(en), .a(c[3*LI+E2]), .b(c[3*RI+E1]), .y(q));
    nm_fp_add u_sub (.clk(clk), .en(en), .a(p), .b({~q[31], q[30:0]}), .y(k[j]));
  end

  // determinant: ((c0x*k0x + c0y*k0y) + c0z*k0z)
  for (genvar e = 0; e < 3; e++) begin : g_dot
    nm_delay #(.W(FP_W), .DEPTH(C0_DELAY)) u_c0d (
      .clk(clk), .en(en), .din(c[e]), .dout(c0d[e])
    );
    nm_fp_mul u_mul (.clk(clk), .en(en), .a(c0d[e]), .b(k[e]), .y(pd[e]));
  end

  nm_delay #(.W(FP_W), .DEPTH(ADD_LAT)) u_pzd (
    .clk(clk), .en(en), .din(pd[2]), .dout(pzd)
  );
  nm_fp_add u_add_s (.clk(clk), .en(en), .a(pd[0]), .b(pd[1]), .y(s));
  nm_fp_add u_add_d (.clk(clk), .en(en), .a(s), .b(pzd), .y(det));

  nm_recip u_recip (.clk(clk), .en(en), .d(det), .r(rcp), .deg(deg));

  // cofactors wait for the reciprocal, then scale
  for (genvar j = 0; j < NUM_ELEM; j++) begin : g_scale
    nm_delay #(.W(FP_W), .DEPTH(K_DELAY)) u_kd (
      .clk(clk), .en(en), .din(k[j]), .dout(kd[j])
    );
    nm_fp_mul u_mul (.clk(clk), .en(en), .a(kd[j]), .b(rcp), .y(y[j]));
  end

  nm_delay #(.W(1), .DEPTH(MUL_LAT)) u_degd (
    .clk(clk), .en(en), .din(deg), .dout(degd)
  );

  // identity on a degenerate determinant, NaNs folded to the quiet pattern
  always_comb begin
    for (int j = 0; j < NUM_ELEM; j++) begin
      if (degd) out_data_nxt[j*FP_W +: FP_W] = ((j % 4) == 0) ? FP_ONE : FP_ZERO;
      else out_data_nxt[j*FP_W +: FP_W] = fp_canon(y[j]);
    end
    out_deg_nxt = degd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_deg_r  <= out_deg_nxt;
    end
  end

  assign out_tvalid = v_r[PIPE_LAT-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  `NM_ASSERT_IMP(a_deg_identity, out_tvalid && out_tuser, mat_is_identity(out_tdata))
  `NM_ASSERT_IMP(a_nan_canon, out_tvalid, mat_nan_canon(out_tdata))
  `NM_ASSERT_NXT(a_last_stage_lands, en && v_r[PIPE_LAT-2], out_tvalid)

endmodule
